// File: rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character table of the Base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  // Default depth of the job queue between front and back (2 or more)
  localparam int QUEUE_DEPTH_DEF = 2;

  // ASCII anchors of the Base64 alphabet
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] PAD_CHAR     = 8'h3D;

  // Sextet ranges of the alphabet
  localparam logic [5:0] SEXT_LOWER = 6'd26;
  localparam logic [5:0] SEXT_DIGIT = 6'd52;
  localparam logic [5:0] SEXT_PLUS  = 6'd62;

  // Bytes already taken in the current three-byte group
  typedef enum logic [1:0] {
    PHASE_0 = 2'd0,
    PHASE_1 = 2'd1,
    PHASE_2 = 2'd2
  } phase_t;

  // Work for one byte: up to four characters
  typedef struct packed {
    logic            is_final;  // last char of this job ends the message
    logic [2:0]      n_chars;   // 1 to 4
    logic [3:0]      pad;       // slot is '=' instead of a sextet
    logic [3:0][5:0] sextet;
  } job_t;

  // Status of the back end, for checking
  typedef struct packed {
    logic       busy;
    logic [1:0] char_idx;
    logic [2:0] n_chars;
  } back_status_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    priority if (v < SEXT_LOWER) begin
      c = CHAR_UPPER_A + {2'b00, v};
    end else if (v < SEXT_DIGIT) begin
      c = CHAR_LOWER_A + {2'b00, v - SEXT_LOWER};
    end else if (v < SEXT_PLUS) begin
      c = CHAR_DIGIT_0 + {2'b00, v - SEXT_DIGIT};
    end else if (v == SEXT_PLUS) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

endpackage

// File: rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Takes raw bytes, tracks group phase and leftover bits, and builds the
// character job each byte completes.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            final_byte,
  output b64e_pkg::job_t  job,
  output b64e_pkg::phase_t phase
);
  import b64e_pkg::*;

  phase_t     phase_next;
  logic [3:0] leftover;
  logic [3:0] leftover_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PHASE_0;
      leftover <= 4'd0;
    end else if (accept) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

  always_comb begin
    job           = '0;
    phase_next    = PHASE_0;
    leftover_next = 4'd0;
    unique case (phase)
      PHASE_1: begin
        job.sextet[0] = {leftover[1:0], data_byte[7:4]};
        if (final_byte) begin
          job.sextet[1] = {data_byte[3:0], 2'b00};
          job.pad[2]    = 1'b1;
          job.n_chars   = 3'd3;
          job.is_final  = 1'b1;
        end else begin
          job.n_chars   = 3'd1;
          phase_next    = PHASE_2;
          leftover_next = data_byte[3:0];
        end
      end
      PHASE_2: begin
        // group complete: always back to the start of a group
        job.sextet[0] = {leftover, data_byte[7:6]};
        job.sextet[1] = data_byte[5:0];
        job.n_chars   = 3'd2;
        job.is_final  = final_byte;
      end
      default: begin
        job.sextet[0] = data_byte[7:2];
        if (final_byte) begin
          job.sextet[1] = {data_byte[1:0], 4'b0000};
          job.pad[2]    = 1'b1;
          job.pad[3]    = 1'b1;
          job.n_chars   = 3'd4;
          job.is_final  = 1'b1;
        end else begin
          job.n_chars   = 3'd1;
          phase_next    = PHASE_1;
          leftover_next = {2'b00, data_byte[1:0]};
        end
      end
    endcase
  end

endmodule

// File: rtl/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Small job FIFO that decouples the byte front end from the char back end.
// ----------------------------------------------------------------------------
module b64e_queue #(
  parameter int DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64e_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output b64e_pkg::job_t pop_job,
  output logic           empty
);
  import b64e_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Walks the current job one character a beat into the output register.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  b64e_pkg::job_t         q_job,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             code_char,
  output logic                   final_char,
  output b64e_pkg::back_status_t status
);
  import b64e_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       out_ready;
  logic       cur_last;
  logic       advance;
  logic [7:0] char_sel;

  assign out_ready = !out_valid || !out_stall;
  assign cur_last  = ({1'b0, idx} == (cur.n_chars - 3'd1));
  assign advance   = cur_valid && out_ready;
  assign q_pop     = !q_empty && (!cur_valid || (advance && cur_last));
  assign char_sel  = cur.pad[idx] ? PAD_CHAR : sextet_char(cur.sextet[idx]);

  assign status.busy     = cur_valid;
  assign status.char_idx = idx;
  assign status.n_chars  = cur.n_chars;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (advance) begin
      if (cur_last) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      code_char  <= char_sel;
      final_char <= cur.is_final && cur_last;
    end
  end

endmodule

// File: rtl/base64_stream_encoder_top.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Streaming RFC 4648 Base64 encoder: raw bytes in, ASCII characters out.
// ----------------------------------------------------------------------------
// Feed the message one byte a beat with final_byte set on its last byte; the
// block returns standard Base64 characters one a beat, padding a short final
// group with '=' and setting final_char on the last character. A new message
// may follow right after a final byte. A byte is taken every cycle while the
// job queue has room (QUEUE_DEPTH jobs, default 2); each byte turns into one
// job of one to four characters. Throughput is set by the output register,
// which sends one character per cycle while out_stall is low: mid-stream
// three bytes make four characters, and a final byte makes up to four. With
// the pipe empty, a byte's first character passes through the job queue, the
// current-job register and the output register.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top #(
  parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEF  // 2 or more
) (
  input  logic       clk,
  input  logic       rst,
  // byte channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  // character channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] code_char,
  output logic       final_char
);
  import b64e_pkg::*;

  logic         in_accept;
  job_t         front_job;
  phase_t       phase;
  logic         q_full;
  logic         q_empty;
  logic         q_pop;
  job_t         q_job;
  back_status_t back_st;

  // Front stalls only on a full queue, never on the output side.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  // Front: group phase and leftover bits, one job per byte beat
  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .job        (front_job),
    .phase      (phase)
  );

  // Decoupling queue of jobs
  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (in_accept),
    .push_job (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_job),
    .empty    (q_empty)
  );

  // Back: one character a beat through the output register
  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_job      (q_job),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_char  (code_char),
    .final_char (final_char),
    .status     (back_st)
  );

  // A final byte always closes the group.
  a_final_resets_phase : assert property (
    @(posedge clk) disable iff (rst)
    in_accept && final_byte |=> phase == PHASE_0
  ) else $error("group phase not cleared after final byte");

  // A non-final byte at group start leaves two bits pending.
  a_phase0_advances : assert property (
    @(posedge clk) disable iff (rst)
    in_accept && !final_byte && phase == PHASE_0 |=> phase == PHASE_1
  ) else $error("group phase did not advance from start of group");

  // The back end never walks past the end of its job.
  a_back_idx_bound : assert property (
    @(posedge clk) disable iff (rst)
    back_st.busy |-> ({1'b0, back_st.char_idx} < back_st.n_chars)
  ) else $error("character index past end of job");

  // Nothing is popped from an empty queue.
  a_no_pop_empty : assert property (
    @(posedge clk) disable iff (rst)
    q_empty |-> !q_pop
  ) else $error("job popped from empty queue");

endmodule

// File: tb/tb_base64_stream_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder_top
// Self-checking bench for the streaming Base64 encoder.
// ----------------------------------------------------------------------------
// Raw bytes go in over the byte channel; every accepted byte is run through a
// local encoder model that queues the characters it should produce. Each
// character beat taken from the block is checked against the oldest queued
// character, field by field. Directed messages cover all group positions and
// both kinds of padding. Random messages follow, with random idling on both
// sides, and one long receiver hold-off fills the block so it stalls its input.
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder_top;
  import b64e_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       final_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] code_char;
  logic       final_char;

  base64_stream_encoder_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_char  (code_char),
    .final_char (final_char)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // One expected character beat
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  char_beat_t pending_chars[$];
  int         err_count = 0;

  // Local encoder state: position in the 3-byte group and the unsent low bits
  phase_t     enc_phase = PHASE_0;
  logic [3:0] enc_carry = 4'h0;
  string      b64_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Pacing controls, flipped by the tests
  bit tx_pace_on = 1'b0;
  bit rx_pace_on = 1'b0;
  int hold_req   = 0;   // receiver hold-off request, in cycles

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    return b64_alphabet[v];
  endfunction

  function automatic void push_char(input logic [7:0] ch, input logic last);
    char_beat_t c;
    c.ch   = ch;
    c.last = last;
    pending_chars.push_back(c);
  endfunction

  // Queue the characters one byte completes and advance the group position.
  // A final byte closes the group and goes back to the start of a group for
  // the next message; a short group zero-fills the last sextet, pads with '='.
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    case (enc_phase)
      PHASE_1: begin
        push_char(b64_char({enc_carry[1:0], b[7:4]}), 1'b0);
        if (fin) begin
          push_char(b64_char({b[3:0], 2'b00}), 1'b0);
          push_char(PAD_CHAR, 1'b1);
          enc_phase = PHASE_0;
          enc_carry = 4'h0;
        end else begin
          enc_phase = PHASE_2;
          enc_carry = b[3:0];
        end
      end
      PHASE_2: begin
        // third byte always completes the group, no padding
        push_char(b64_char({enc_carry, b[7:6]}), 1'b0);
        push_char(b64_char(b[5:0]), fin);
        enc_phase = PHASE_0;
        enc_carry = 4'h0;
      end
      default: begin
        push_char(b64_char(b[7:2]), 1'b0);
        if (fin) begin
          push_char(b64_char({b[1:0], 4'h0}), 1'b0);
          push_char(PAD_CHAR, 1'b0);
          push_char(PAD_CHAR, 1'b1);
          enc_phase = PHASE_0;
          enc_carry = 4'h0;
        end else begin
          enc_phase = PHASE_1;
          enc_carry = {2'b00, b[1:0]};
        end
      end
    endcase
  endfunction

  // Idle length: mostly short, now and then long
  function automatic int gap_len();
    if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one byte beat and hold it until taken. valid is only lowered when
  // a gap is inserted, so a back-to-back beat sees a single assignment.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = (tx_pace_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    final_byte <= fin;
    do @(posedge clk); while (in_stall);
    encode_byte(b, fin);
  endtask

  // Random byte, biased toward the all-zero and all-one extremes
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_byte(rand_byte(), i == len - 1);
  endtask

  // Receiver pacing. A hold-off request wins over random stalls and is
  // counted down here, independent of what the sender is doing.
  initial begin : rx_pacing
    int run_len;
    int hold_cnt;
    run_len  = 0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (run_len > 0) begin
        run_len--;
        out_stall <= 1'b1;
      end else if (rx_pace_on && $urandom_range(0, 2) == 0) begin
        run_len = gap_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Character checker: every accepted beat must match the oldest expectation
  always @(posedge clk) begin : check_chars
    char_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char beat, expected none, actual %h final %b",
                 $time, code_char, final_char);
        err_count++;
      end else begin
        want = pending_chars.pop_front();
        if (code_char !== want.ch) begin
          $display("%0t: code_char mismatch, expected %h, actual %h",
                   $time, want.ch, code_char);
          err_count++;
        end
        if (final_char !== want.last) begin
          $display("%0t: final_char mismatch, expected %b, actual %b",
                   $time, want.last, final_char);
          err_count++;
        end
      end
    end
  end

  // One-byte messages: final at the start of a group, two '=' pads
  task automatic test_one_byte_messages();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  // Two-byte messages: final in mid group, one '=' pad; top bit set and clear
  task automatic test_two_byte_messages();
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // Full groups with no padding, then a group plus a short tail
  task automatic test_full_groups();
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    // group, then a final second byte: state must carry across the group
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hC0, 1'b1);
  endtask

  // Random messages, pacing reshuffled per message, stretches with none
  task automatic test_random_messages(input int n_bytes);
    int sent;
    int len;
    sent = 0;
    while (sent < n_bytes) begin
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 30);
      tx_pace_on = ($urandom_range(0, 3) != 0);
      rx_pace_on = ($urandom_range(0, 3) != 0);
      send_message(len);
      sent += len;
    end
    tx_pace_on = 1'b0;
    rx_pace_on = 1'b0;
  endtask

  // Receiver holds off for a long stretch while bytes keep coming with no
  // gaps: the job queue fills and the block must stall its byte channel
  task automatic test_backpressure();
    tx_pace_on = 1'b0;
    rx_pace_on = 1'b0;
    hold_req   = 80;
    send_message(7);
    send_message(11);
    send_message(5);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_one_byte_messages();
    test_two_byte_messages();
    test_full_groups();
    test_backpressure();
    test_random_messages(235);
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
